// File: rtl/tsg_pkg.sv
package tsg_pkg;

  // coordinate width is fixed by the transaction formats
  localparam int COORD_BITS = 12;
  // error terms and diagonal increment, range about +-2^(COORD_BITS+1)
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int INC_BITS   = COORD_BITS + 2;
  // step counter, top bit set means the per-walk step limit 2^(COORD_BITS+1) was hit
  localparam int CNT_BITS   = COORD_BITS + 2;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SPAN = 1'b1;

  // edge octants
  localparam logic [1:0] OCT_XR = 2'd0;  // x-major, going right
  localparam logic [1:0] OCT_YR = 2'd1;  // y-major, going right
  localparam logic [1:0] OCT_YL = 2'd2;  // y-major, going left
  localparam logic [1:0] OCT_XL = 2'd3;  // x-major, going left

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [1:0]            edge_sel_t;

  typedef struct packed {
    logic   req_type;
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_c_x;
    coord_t vertex_c_y;
  } tsg_in_t;

  typedef struct packed {
    coord_t span_row;
    coord_t span_left;
    coord_t span_right;
    logic   span_valid;
    logic   last_span;
  } tsg_out_t;

  typedef struct packed {
    coord_t                      cur_x;
    coord_t                      cur_y;
    coord_t                      end_y;
    logic signed [ERR_BITS-1:0]  error;
    logic        [INC_BITS-1:0]  inc_straight;
    logic signed [ERR_BITS-1:0]  inc_diagonal;
    logic        [1:0]           octant;
  } edge_t;

endpackage

// File: rtl/triangle_span_generator.sv
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_ready   | tsg_in_t: request type, three vertices
// out_    | output    | out_valid / out_ready | tsg_out_t: row, left, right, valid, last
//
// load transaction: accept, set up each edge in turn, then order the short edges
// span transaction: accept, check, walk the long edge, pick, walk the short edge,
//   then the result is held; every Bresenham step of an edge goes through the
//   single shared step unit, so x-major edges take one step per pixel column
// in_ready is high only while idle; a result stalls the block until out_ready
// reset (rst_n low, synchronous) clears all edges to zero, long/upper/lower = 0/1/2
module triangle_span_generator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tsg_pkg::tsg_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tsg_pkg::tsg_out_t out_data
);
  import tsg_pkg::*;

  // sequencer states
  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_SETUP      = 4'd1;  // set up edge idx_r
  localparam logic [3:0] ST_ORDER_A    = 4'd2;  // read start y of first short edge
  localparam logic [3:0] ST_ORDER_B    = 4'd3;  // compare with second, pick upper/lower
  localparam logic [3:0] ST_CHECK      = 4'd4;  // long edge exhausted?
  localparam logic [3:0] ST_WALK_LONG  = 4'd5;  // step long edge until y changes
  localparam logic [3:0] ST_PICK       = 4'd6;  // choose the short edge for this row
  localparam logic [3:0] ST_WALK_SHORT = 4'd7;  // step short edge up to the row
  localparam logic [3:0] ST_OUT        = 4'd8;  // hold result until taken

  function automatic edge_sel_t next_sel(input edge_sel_t s);
    edge_sel_t r;
    case (s)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      2'd2:    r = 2'd0;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  logic [3:0]            state_r, state_nxt;
  edge_sel_t             idx_r, idx_nxt;
  edge_sel_t             long_r, long_nxt;
  edge_sel_t             upper_r, upper_nxt;
  edge_sel_t             lower_r, lower_nxt;
  tsg_in_t               vtx_r, vtx_nxt;
  logic [COORD_BITS-1:0] best_r, best_nxt;
  coord_t                ya_r, ya_nxt;
  coord_t                oy_r, oy_nxt;
  coord_t                row_r, row_nxt;
  coord_t                lx_r, lx_nxt;
  coord_t                endl_r, endl_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  tsg_out_t              out_r, out_nxt;

  // three-entry edge register file, one read and one write index (idx_r)
  edge_t                 edge_r [3];
  edge_t                 rd_edge;
  edge_t                 wr_data;
  logic                  wr_en;

  // shared units
  coord_t                su_x1, su_y1, su_x2, su_y2;
  edge_t                 su_edge;
  logic [COORD_BITS-1:0] su_len;
  edge_t                 step_edge;
  logic                  step_ok;

  assign rd_edge = edge_r[idx_r];
  // walk stops after 2^(COORD_BITS+1) steps
  assign step_ok = !cnt_r[CNT_BITS-1];

  // edge 0 = a-b, edge 1 = a-c, edge 2 = c-b
  always_comb begin
    case (idx_r)
      2'd1: begin
        su_x1 = vtx_r.vertex_a_x;
        su_y1 = vtx_r.vertex_a_y;
        su_x2 = vtx_r.vertex_c_x;
        su_y2 = vtx_r.vertex_c_y;
      end
      2'd2: begin
        su_x1 = vtx_r.vertex_c_x;
        su_y1 = vtx_r.vertex_c_y;
        su_x2 = vtx_r.vertex_b_x;
        su_y2 = vtx_r.vertex_b_y;
      end
      default: begin
        su_x1 = vtx_r.vertex_a_x;
        su_y1 = vtx_r.vertex_a_y;
        su_x2 = vtx_r.vertex_b_x;
        su_y2 = vtx_r.vertex_b_y;
      end
    endcase
  end

  tsg_edge_setup u_setup (
    .x1     (su_x1),
    .y1     (su_y1),
    .x2     (su_x2),
    .y2     (su_y2),
    .edge_o (su_edge),
    .len_o  (su_len)
  );

  tsg_edge_step u_step (
    .edge_i (rd_edge),
    .edge_o (step_edge)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    long_nxt  = long_r;
    upper_nxt = upper_r;
    lower_nxt = lower_r;
    vtx_nxt   = vtx_r;
    best_nxt  = best_r;
    ya_nxt    = ya_r;
    oy_nxt    = oy_r;
    row_nxt   = row_r;
    lx_nxt    = lx_r;
    endl_nxt  = endl_r;
    cnt_nxt   = cnt_r;
    out_nxt   = out_r;
    wr_en     = 1'b0;
    wr_data   = step_edge;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          vtx_nxt = in_data;
          if (in_data.req_type == REQ_LOAD) begin
            idx_nxt   = 2'd0;
            best_nxt  = '0;
            long_nxt  = 2'd0;
            state_nxt = ST_SETUP;
          end else begin
            idx_nxt   = long_r;
            state_nxt = ST_CHECK;
          end
        end
      end

      ST_SETUP: begin
        wr_en   = 1'b1;
        wr_data = su_edge;
        // strict compare keeps the lowest edge number on a tie
        if (su_len > best_r) begin
          best_nxt = su_len;
          long_nxt = idx_r;
        end
        if (idx_r == 2'd2) begin
          idx_nxt   = next_sel(long_nxt);
          state_nxt = ST_ORDER_A;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end

      ST_ORDER_A: begin
        ya_nxt    = rd_edge.cur_y;
        idx_nxt   = next_sel(idx_r);
        state_nxt = ST_ORDER_B;
      end

      ST_ORDER_B: begin
        // equal start rows make edge (long+1) mod 3 the upper one
        if (ya_r > rd_edge.cur_y) begin
          lower_nxt = next_sel(long_r);
          upper_nxt = idx_r;
        end else begin
          upper_nxt = next_sel(long_r);
          lower_nxt = idx_r;
        end
        state_nxt = ST_IDLE;
      end

      ST_CHECK: begin
        if (rd_edge.cur_y >= rd_edge.end_y) begin
          // exhausted or zero height: empty answer
          out_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          oy_nxt    = rd_edge.cur_y;
          endl_nxt  = rd_edge.end_y;
          cnt_nxt   = '0;
          state_nxt = ST_WALK_LONG;
        end
      end

      ST_WALK_LONG: begin
        if ((rd_edge.cur_y == oy_r) && step_ok) begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + CNT_BITS'(1);
        end else begin
          row_nxt   = rd_edge.cur_y;
          lx_nxt    = rd_edge.cur_x;
          idx_nxt   = upper_r;
          state_nxt = ST_PICK;
        end
      end

      ST_PICK: begin
        idx_nxt   = (row_r <= rd_edge.end_y) ? upper_r : lower_r;
        cnt_nxt   = '0;
        state_nxt = ST_WALK_SHORT;
      end

      ST_WALK_SHORT: begin
        if ((rd_edge.cur_y < row_r) && step_ok) begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + CNT_BITS'(1);
        end else begin
          out_nxt.span_row   = row_r;
          out_nxt.span_left  = (rd_edge.cur_x < lx_r) ? rd_edge.cur_x : lx_r;
          out_nxt.span_right = (rd_edge.cur_x < lx_r) ? lx_r : rd_edge.cur_x;
          out_nxt.span_valid = 1'b1;
          out_nxt.last_span  = (row_r >= endl_r);
          state_nxt          = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= 2'd0;
      long_r  <= 2'd0;
      upper_r <= 2'd1;
      lower_r <= 2'd2;
      best_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      long_r  <= long_nxt;
      upper_r <= upper_nxt;
      lower_r <= lower_nxt;
      best_r  <= best_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // edge state is read after reset, so it is cleared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r[0] <= '0;
      edge_r[1] <= '0;
      edge_r[2] <= '0;
    end else if (wr_en) begin
      edge_r[idx_r] <= wr_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    vtx_r  <= vtx_nxt;
    ya_r   <= ya_nxt;
    oy_r   <= oy_nxt;
    row_r  <= row_nxt;
    lx_r   <= lx_nxt;
    endl_r <= endl_nxt;
    out_r  <= out_nxt;
  end

  // while idle the edge roles long, upper and lower name different edges
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |->
      (long_r != upper_r) && (long_r != lower_r) && (upper_r != lower_r))
    else $error("edge roles overlap");

  // a produced span is ordered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.span_valid |-> out_data.span_left <= out_data.span_right)
    else $error("span bounds out of order");

  // an empty answer carries all-zero fields
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.span_valid |->
      (out_data.span_row == '0) && (out_data.span_left == '0) &&
      (out_data.span_right == '0) && !out_data.last_span)
    else $error("empty span carries data");

  // no edge write from a walk once the step limit is reached
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && ((state_r == ST_WALK_LONG) || (state_r == ST_WALK_SHORT)) |->
      !cnt_r[CNT_BITS-1])
    else $error("edge stepped past the step limit");

endmodule

// File: rtl/tsg_edge_setup.sv
module tsg_edge_setup (
  input  tsg_pkg::coord_t                     x1,
  input  tsg_pkg::coord_t                     y1,
  input  tsg_pkg::coord_t                     x2,
  input  tsg_pkg::coord_t                     y2,
  output tsg_pkg::edge_t                      edge_o,
  output logic [tsg_pkg::COORD_BITS-1:0]      len_o
);
  import tsg_pkg::*;

  coord_t                  xb;
  coord_t                  yb;
  coord_t                  xe;
  coord_t                  ye;
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS-1:0]   adx;
  logic [COORD_BITS-1:0]   udy;
  logic [COORD_BITS-1:0]   major;
  logic [COORD_BITS-1:0]   minor;
  logic                    x_neg;
  logic                    y_major;

  always_comb begin
    // start at the lower y end, second vertex wins a tie
    if (y1 < y2) begin
      xb = x1;
      yb = y1;
      xe = x2;
      ye = y2;
    end else begin
      xb = x2;
      yb = y2;
      xe = x1;
      ye = y1;
    end
    dx      = (COORD_BITS+1)'(xe) - (COORD_BITS+1)'(xb);
    dy      = (COORD_BITS+1)'(ye) - (COORD_BITS+1)'(yb);
    x_neg   = dx[COORD_BITS];
    adx     = x_neg ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    udy     = COORD_BITS'(dy);
    y_major = udy > adx;
    major   = y_major ? udy : adx;
    minor   = y_major ? adx : udy;

    if (y_major) begin
      edge_o.octant = x_neg ? OCT_YL : OCT_YR;
    end else begin
      edge_o.octant = x_neg ? OCT_XL : OCT_XR;
    end
    edge_o.error        = ERR_BITS'({minor, 1'b0}) - ERR_BITS'(major);
    edge_o.inc_straight = INC_BITS'({minor, 1'b0});
    edge_o.inc_diagonal = ERR_BITS'({minor, 1'b0}) - ERR_BITS'({major, 1'b0});
    edge_o.cur_x        = xb;
    edge_o.cur_y        = yb;
    edge_o.end_y        = ye;
    len_o               = udy;
  end

endmodule

// File: rtl/tsg_edge_step.sv
module tsg_edge_step (
  input  tsg_pkg::edge_t edge_i,
  output tsg_pkg::edge_t edge_o
);
  import tsg_pkg::*;

  logic diag;

  always_comb begin
    diag   = !edge_i.error[ERR_BITS-1];
    edge_o = edge_i;
    edge_o.error = edge_i.error +
                   (diag ? edge_i.inc_diagonal : ERR_BITS'(edge_i.inc_straight));
    case (edge_i.octant)
      OCT_XR: begin
        edge_o.cur_x = edge_i.cur_x + coord_t'(1);
        if (diag) edge_o.cur_y = edge_i.cur_y + coord_t'(1);
      end
      OCT_YR: begin
        edge_o.cur_y = edge_i.cur_y + coord_t'(1);
        if (diag) edge_o.cur_x = edge_i.cur_x + coord_t'(1);
      end
      OCT_YL: begin
        edge_o.cur_y = edge_i.cur_y + coord_t'(1);
        if (diag) edge_o.cur_x = edge_i.cur_x - coord_t'(1);
      end
      default: begin
        edge_o.cur_x = edge_i.cur_x - coord_t'(1);
        if (diag) edge_o.cur_y = edge_i.cur_y + coord_t'(1);
      end
    endcase
  end

endmodule

// File: dv/triangle_span_generator_tb.sv
`timescale 1ns / 1ps

module triangle_span_generator_tb;
  import tsg_pkg::*;

  // any single walk of an edge gives up after this many steps
  localparam int STEP_LIMIT  = 1 << (COORD_BITS + 1);
  // cycles without any transaction before the run is declared hung
  localparam int HANG_LIMIT  = 60000;
  localparam int RAND_ITEMS  = 1400;
  // no idling on either side during every fourth block of this many transactions
  localparam int QUIET_BLOCK = 150;

  typedef struct {
    tsg_in_t item;
    bit      drain;  // hold this one back until every span has come back
  } pending_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  tsg_in_t   in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  tsg_out_t  out_data;

  pending_t  stim_q[$];
  tsg_out_t  span_expect_q[$];

  // shadow copy of every edge and of the edge roles
  int        seg_x[3]     = '{0, 0, 0};
  int        seg_y[3]     = '{0, 0, 0};
  int        seg_end[3]   = '{0, 0, 0};
  int        seg_err[3]   = '{0, 0, 0};
  int        seg_inc_s[3] = '{0, 0, 0};
  int        seg_inc_d[3] = '{0, 0, 0};
  logic [1:0] seg_oct[3]  = '{OCT_XR, OCT_XR, OCT_XR};
  edge_sel_t long_sel  = 2'd0;
  edge_sel_t upper_sel = 2'd1;
  edge_sel_t lower_sel = 2'd2;

  int        queued_cnt   = 0;
  int        sent_cnt     = 0;
  int        got_cnt      = 0;
  int        mismatch_cnt = 0;
  int        send_gap     = 0;
  int        recv_gap     = 0;
  int        hold_cnt     = 0;
  int        hang_cnt     = 0;

  triangle_span_generator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // span predictor
  // ---------------------------------------------------------------------------

  // order the edge by y, pick its octant and set up the Bresenham terms
  function automatic void setup_seg(int k, int x1, int y1, int x2, int y2);
    int xb, yb, xe, ye, dx, dy, t;
    if (y1 < y2) begin
      xb = x1; yb = y1; xe = x2; ye = y2;
    end else begin
      // equal y takes the second vertex as start
      xb = x2; yb = y2; xe = x1; ye = y1;
    end
    dx = xe - xb;
    dy = ye - yb;
    if (dx >= 0) begin
      if (dy > dx) begin
        seg_oct[k] = OCT_YR;
        t = dx; dx = dy; dy = t;
      end else begin
        seg_oct[k] = OCT_XR;
      end
    end else begin
      if (dy > -dx) begin
        seg_oct[k] = OCT_YL;
        t = dx; dx = dy; dy = t;
      end else begin
        seg_oct[k] = OCT_XL;
      end
    end
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    seg_err[k]   = 2 * dy - dx;
    seg_inc_s[k] = 2 * dy;
    seg_inc_d[k] = 2 * (dy - dx);
    seg_x[k]     = xb;
    seg_y[k]     = yb;
    seg_end[k]   = ye;
  endfunction

  // one Bresenham step along the major axis, diagonal when the error is non-negative
  function automatic void step_seg(int k);
    bit diag;
    diag = (seg_err[k] >= 0);
    seg_err[k] += diag ? seg_inc_d[k] : seg_inc_s[k];
    case (seg_oct[k])
      OCT_XR: begin
        seg_x[k] += 1;
        if (diag) seg_y[k] += 1;
      end
      OCT_YR: begin
        seg_y[k] += 1;
        if (diag) seg_x[k] += 1;
      end
      OCT_YL: begin
        seg_y[k] += 1;
        if (diag) seg_x[k] -= 1;
      end
      default: begin
        seg_x[k] -= 1;
        if (diag) seg_y[k] += 1;
      end
    endcase
  endfunction

  // applies one accepted transaction to the shadow state, queues the span a span request answers
  function automatic void model_transaction(tsg_in_t t);
    int k, len, best, a, b, lg, up, sh, oy, row, sx, lx, n;
    tsg_out_t r;
    if (t.req_type == REQ_LOAD) begin
      setup_seg(0, t.vertex_a_x, t.vertex_a_y, t.vertex_b_x, t.vertex_b_y);
      setup_seg(1, t.vertex_a_x, t.vertex_a_y, t.vertex_c_x, t.vertex_c_y);
      setup_seg(2, t.vertex_c_x, t.vertex_c_y, t.vertex_b_x, t.vertex_b_y);
      // strict compare keeps the lowest edge number on equal heights
      best = 0;
      lg   = 0;
      for (k = 0; k < 3; k++) begin
        len = seg_end[k] - seg_y[k];
        if (len > best) begin
          best = len;
          lg   = k;
        end
      end
      a = (lg + 1) % 3;
      b = (lg + 2) % 3;
      long_sel = edge_sel_t'(lg);
      if (seg_y[a] > seg_y[b]) begin
        lower_sel = edge_sel_t'(a);
        upper_sel = edge_sel_t'(b);
      end else begin
        upper_sel = edge_sel_t'(a);
        lower_sel = edge_sel_t'(b);
      end
      return;
    end
    lg = long_sel;
    up = upper_sel;
    r  = '0;
    // exhausted or flat triangle answers an all-zero span
    if (seg_y[lg] < seg_end[lg]) begin
      oy = seg_y[lg];
      n  = 0;
      while (seg_y[lg] == oy && n < STEP_LIMIT) begin
        step_seg(lg);
        n++;
      end
      row = seg_y[lg];
      sh  = (row <= seg_end[up]) ? up : int'(lower_sel);
      n   = 0;
      while (seg_y[sh] < row && n < STEP_LIMIT) begin
        step_seg(sh);
        n++;
      end
      sx = seg_x[sh];
      lx = seg_x[lg];
      r.span_row   = coord_t'(row);
      r.span_left  = coord_t'((sx < lx) ? sx : lx);
      r.span_right = coord_t'((sx < lx) ? lx : sx);
      r.span_valid = 1'b1;
      r.last_span  = (row >= seg_end[lg]);
    end
    span_expect_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic void push_item(tsg_in_t t, bit drain);
    pending_t p;
    p.item  = t;
    p.drain = drain;
    stim_q.push_back(p);
    queued_cnt++;
  endfunction

  function automatic void push_load(int ax, int ay, int bx, int by, int cx, int cy, bit drain);
    tsg_in_t t;
    t.req_type   = REQ_LOAD;
    t.vertex_a_x = coord_t'(ax);
    t.vertex_a_y = coord_t'(ay);
    t.vertex_b_x = coord_t'(bx);
    t.vertex_b_y = coord_t'(by);
    t.vertex_c_x = coord_t'(cx);
    t.vertex_c_y = coord_t'(cy);
    push_item(t, drain);
  endfunction

  // span requests carry random vertex fields, which the block must ignore
  function automatic void push_spans(int n);
    logic [95:0] noise;
    tsg_in_t t;
    for (int i = 0; i < n; i++) begin
      noise = {$urandom(), $urandom(), $urandom()};
      t = noise[$bits(tsg_in_t)-1:0];
      t.req_type = REQ_SPAN;
      push_item(t, 1'b0);
    end
  endfunction

  // one random triangle, mostly small so that the Bresenham walks stay short
  function automatic void push_random_sequence(bit drain);
    int pick, xspan, yspan, ox, oy, ymin, ymax, h, shape;
    int vx[3];
    int vy[3];
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      xspan = $urandom_range(0, 12);
      yspan = $urandom_range(0, 8);
    end else if (pick < 88) begin
      xspan = $urandom_range(0, 60);
      yspan = $urandom_range(0, 40);
    end else if (pick < 95) begin
      // wide and flat: x-major edges, one step per column
      xspan = $urandom_range(0, 1500);
      yspan = $urandom_range(0, 4);
    end else begin
      // tall and narrow
      xspan = $urandom_range(0, 100);
      yspan = $urandom_range(100, 400);
    end
    ox = int'($urandom_range(0, 4095 - xspan)) - 2048;
    oy = int'($urandom_range(0, 4095 - yspan)) - 2048;
    for (int i = 0; i < 3; i++) begin
      vx[i] = ox + int'($urandom_range(0, xspan));
      vy[i] = oy + int'($urandom_range(0, yspan));
    end
    // force shared rows and vertical edges now and then
    case ($urandom_range(0, 9))
      0: vy[1] = vy[0];
      1: vy[2] = vy[1];
      2: vy[2] = vy[0];
      3: vx[2] = vx[0];
      4: begin
        vy[1] = vy[0];
        vy[2] = vy[0];
      end
      default: ;
    endcase
    ymin = vy[0];
    ymax = vy[0];
    for (int i = 1; i < 3; i++) begin
      if (vy[i] < ymin) ymin = vy[i];
      if (vy[i] > ymax) ymax = vy[i];
    end
    h = ymax - ymin;
    shape = $urandom_range(0, 99);
    if (shape < 80) begin
      // whole triangle, then up to two requests past the end
      push_load(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], drain);
      push_spans(h + $urandom_range(0, 2));
    end else if (shape < 90) begin
      // cut short by the next load
      push_load(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], drain);
      push_spans($urandom_range(0, h));
    end else if (shape < 95) begin
      // stray span requests on whatever is left over
      push_spans($urandom_range(1, 3));
    end else begin
      // load overwritten before any span
      push_load(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], drain);
    end
  endfunction

  initial begin
    int seq_no;
    // span straight after reset: nothing loaded, exhausted
    push_spans(1);
    // full-height triangle at the coordinate extremes, long x-major short edge
    push_load(-2048, -2048, 2047, -2047, -2048, 2047, 1'b0);
    push_spans(2);
    // mirrored extremes, walking left
    push_load(2047, 2047, -2048, 2046, 2047, -2048, 1'b0);
    push_spans(2);
    // flat bottom, full walk plus one request past the end
    push_load(0, 0, 4, 0, 2, 3, 1'b0);
    push_spans(4);
    // equal edge heights, the lowest edge number stays the long edge
    push_load(0, 0, 3, 3, -3, 3, 1'b0);
    push_spans(4);
    // zero height, sent only once every earlier span has come back
    push_load(1, 5, 9, 5, -4, 5, 1'b1);
    push_spans(1);
    // all three vertices on one point
    push_load(7, 7, 7, 7, 7, 7, 1'b0);
    push_spans(1);
    // zero-width spans along a vertical sliver
    push_load(-5, -2, -5, 1, -5, -1, 1'b0);
    push_spans(3);

    // random part; up to two of the loads wait for the block to drain first
    seq_no = 0;
    while (queued_cnt < RAND_ITEMS) begin
      push_random_sequence(seq_no == 0 || seq_no == 120);
      seq_no++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (stim_q.size() != 0 || in_valid || span_expect_q.size() != 0);
    // room for any stray span the block might still put out
    repeat (64) @(negedge clk);

    if (mismatch_cnt == 0 && span_expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: request channel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        model_transaction(in_data);
        sent_cnt++;
        send_gap = ((sent_cnt / QUIET_BLOCK) % 4 == 3) ? 0 : $urandom_range(0, 3);
      end
      // a pending transaction stays on the bus untouched until taken
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (stim_q.size() != 0 &&
                     (!stim_q[0].drain || span_expect_q.size() == 0)) begin
          in_data  <= stim_q[0].item;
          in_valid <= 1'b1;
          void'(stim_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: span channel
  // ---------------------------------------------------------------------------
  function automatic void check_span(tsg_out_t act);
    tsg_out_t exp_span;
    if (span_expect_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t: unexpected span row=%0d left=%0d right=%0d valid=%0b last=%0b",
                 $realtime, act.span_row, act.span_left, act.span_right,
                 act.span_valid, act.last_span);
      return;
    end
    exp_span = span_expect_q.pop_front();
    if (act.span_row   !== exp_span.span_row   || act.span_left  !== exp_span.span_left  ||
        act.span_right !== exp_span.span_right || act.span_valid !== exp_span.span_valid ||
        act.last_span  !== exp_span.last_span) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $write("%0t: span mismatch exp row=%0d left=%0d right=%0d valid=%0b last=%0b,",
               $realtime, exp_span.span_row, exp_span.span_left, exp_span.span_right,
               exp_span.span_valid, exp_span.last_span);
        $display(" act row=%0d left=%0d right=%0d valid=%0b last=%0b",
                 act.span_row, act.span_left, act.span_right, act.span_valid,
                 act.last_span);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap = 0;
      hold_cnt = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_span(out_data);
        got_cnt++;
        recv_gap = ((got_cnt / QUIET_BLOCK) % 4 == 3) ? 0 : $urandom_range(0, 3);
        // long back-pressure while requests keep coming, input has to stall
        if (got_cnt == 300 || got_cnt == 900) hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // hang watchdog: no transaction on either channel for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        hang_cnt = 0;
      end else begin
        hang_cnt++;
        if (hang_cnt >= HANG_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

endmodule
